/* rtl/timed_midi_event_dispatcher_assert.svh */
// ============================================================================
// Assertion macros for the timed MIDI event dispatcher
// Concurrent checks that compile away in synthesis builds.
// ============================================================================
`ifndef TIMED_MIDI_EVENT_DISPATCHER_ASSERT_SVH
`define TIMED_MIDI_EVENT_DISPATCHER_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TMED_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tmed assertion failed");
// next-cycle implication
`define TMED_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tmed assertion failed");
`else
`define TMED_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TMED_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/tmed_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// tmed_pkg
// Shared types, codes and helpers of the timed MIDI event dispatcher.
// ============================================================================
package tmed_pkg;

    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int CHANNELS_DEF    = 16;
    localparam int NOTES           = 128;
    localparam int NOTE_W          = 7;
    localparam int BLK_IDX_W       = 5;

    // input opcodes
    localparam logic [1:0] OP_SCHED = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_PANIC = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    // event kinds of a scheduled item
    localparam logic [1:0] EV_ON  = 2'd0;
    localparam logic [1:0] EV_OFF = 2'd1;
    localparam logic [1:0] EV_ALL = 2'd2;
    localparam logic [1:0] EV_CC  = 2'd3;

    // result kinds
    localparam logic [2:0] KIND_ON  = 3'd0;
    localparam logic [2:0] KIND_OFF = 3'd1;
    localparam logic [2:0] KIND_ALL = 3'd2;
    localparam logic [2:0] KIND_CC  = 3'd3;
    localparam logic [2:0] KIND_OVF = 3'd4;

    localparam logic [1:0] BLK_FIRST = 2'd0;
    localparam logic [1:0] BLK_LAST  = 2'd3;

    typedef struct packed {
        logic [2:0] kind;
        logic [4:0] ch;
        logic [6:0] note;
        logic [6:0] value;
        logic [6:0] ctl;
    } t_result;

    typedef struct packed {
        logic    push;
        logic    flush;
        t_result res;
    } t_ob_ctl;

    typedef struct packed {
        logic [31:0] due;
        logic [1:0]  kind;
        logic [4:0]  ch;
        logic [6:0]  note;
        logic [6:0]  value;
        logic [6:0]  ctl;
        logic [31:0] inst;
    } t_entry;

    typedef struct packed {
        logic        active;
        logic [31:0] inst;
    } t_note_word;

    function automatic t_result mk_res(logic [2:0] kind, logic [4:0] ch, logic [6:0] note,
                                       logic [6:0] value, logic [6:0] ctl);
        t_result r;
        r.kind  = kind;
        r.ch    = ch;
        r.note  = note;
        r.value = value;
        r.ctl   = ctl;
        return r;
    endfunction

endpackage

/* rtl/tmed_ram.sv */
`timescale 1ns / 1ps
// ============================================================================
// tmed_ram
// Simple dual-port memory: one write port, one read port, registered read.
// ============================================================================
module tmed_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* rtl/tmed_obuf.sv */
`timescale 1ns / 1ps
// ============================================================================
// tmed_obuf
// One-deep hold stage plus output register; marks the final result of an item.
// ============================================================================
module tmed_obuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tmed_pkg::t_ob_ctl i_ctl,
    output logic             o_ready,
    input  logic             i_stall,
    output logic             o_valid,
    output tmed_pkg::t_result o_res,
    output logic             o_last
);
    import tmed_pkg::*;

    logic    r_hv;
    t_result r_hold;
    logic    r_ov;
    t_result r_out;
    logic    r_last;
    logic    out_free;

    assign out_free = !r_ov || !i_stall;
    assign o_ready  = !r_hv || out_free;
    assign o_valid  = r_ov;
    assign o_res    = r_out;
    assign o_last   = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (out_free) begin
                r_ov <= 1'b0;
            end
            if (i_ctl.push && o_ready) begin
                // a newer result exists, so the held one is not the last
                if (r_hv) begin
                    r_ov   <= 1'b1;
                    r_out  <= r_hold;
                    r_last <= 1'b0;
                end
                r_hv   <= 1'b1;
                r_hold <= i_ctl.res;
            end else if (i_ctl.flush && o_ready && r_hv) begin
                r_ov   <= 1'b1;
                r_out  <= r_hold;
                r_last <= 1'b1;
                r_hv   <= 1'b0;
            end
        end
    end

endmodule

/* rtl/timed_midi_event_dispatcher.sv */
`timescale 1ns / 1ps
// ============================================================================
// timed_midi_event_dispatcher
// Due-time ordered MIDI event store with an active-note table.
// ============================================================================
// Input channel i_valid/o_stall carries schedule, tick, panic and clear items;
// result channel o_valid/i_stall carries MIDI messages, o_last marking the
// final result of an item. i_cfg_we/i_cfg_wdata writes the running bit.
// One item is worked at a time; o_stall is high while it is in progress.
// Work after the transfer of an item:
//   schedule: each later entry in the pending memory moves up one place (up to
//             QUEUE_DEPTH-1); when the store is full an overflow is flagged
//   tick: each due event is dispatched (none with an empty store), and an all
//         notes off on a valid channel sweeps its notes in the note memory
//   panic block: each note of the block is read and checked; none off the table
//   clear, or tick while stopped: none, the next item is taken the cycle after
// The pending store is a circular buffer in one memory; the note table is a
// second memory of CHANNELS*128 entries, each step a read then a write.
// After reset a clearing pass writes every note memory entry while no item
// is accepted. The result side has a hold stage and an output register, so
// a stalled receiver only holds the sequencer once both fill.
// ============================================================================
module timed_midi_event_dispatcher #(
    parameter int QUEUE_DEPTH = tmed_pkg::QUEUE_DEPTH_DEF,
    parameter int CHANNELS    = tmed_pkg::CHANNELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_time_ms,
    input  logic [1:0]  i_event_kind,
    input  logic [4:0]  i_channel,
    input  logic [6:0]  i_note,
    input  logic [6:0]  i_value,
    input  logic [6:0]  i_controller,
    input  logic [31:0] i_instance_id,
    input  logic [1:0]  i_panic_block,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_out_kind,
    output logic [4:0]  o_out_channel,
    output logic [6:0]  o_out_note,
    output logic [6:0]  o_out_value,
    output logic [6:0]  o_out_controller,
    output logic        o_last
);
    import tmed_pkg::*;
    `include "timed_midi_event_dispatcher_assert.svh"

    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int NA = CW + NOTE_W;
    localparam int ND = CHANNELS * NOTES;
    localparam logic [NA-1:0] CLR_LAST = NA'(ND - 1);
    localparam logic [QW:0]   QFULL    = (QW+1)'(QUEUE_DEPTH);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_INS_RD, S_INS_CMP, S_TK_RD, S_TK_CMP, S_TK_NRD, S_TK_EXEC,
        S_ALL_SWEEP, S_PN_RD, S_PN_CHK, S_PN_END, S_OVF, S_FIN
    } t_state;

    t_state r_state, n_state;
    logic [QW:0]   r_count, n_count;
    logic [QW-1:0] r_head, n_head;
    logic [QW:0]   r_pos, n_pos;
    logic          r_seen, n_seen;
    logic          r_running, n_running;
    logic [NA-1:0] r_clr, n_clr;
    logic [6:0]    r_sweep, n_sweep;
    logic [4:0]    r_pidx, n_pidx;
    t_entry        r_ent, n_ent;

    logic [31:0] r_t;
    logic [1:0]  r_kind;
    logic [4:0]  r_ch;
    logic [6:0]  r_note;
    logic [6:0]  r_val;
    logic [6:0]  r_ctl;
    logic [31:0] r_id;
    logic [1:0]  r_blk;

    logic          in_acc;
    logic          q_we;
    logic [QW-1:0] q_waddr, q_raddr;
    t_entry        q_wdata, q_rd, new_ent;
    logic [$bits(t_entry)-1:0] q_rdata;

    logic          nm_we;
    logic [NA-1:0] nm_waddr, nm_raddr;
    t_note_word    nm_wdata, nm_rd;
    logic [$bits(t_note_word)-1:0] nm_rdata;

    t_ob_ctl ob_ctl;
    logic    ob_ready;
    t_result ob_res;

    function automatic logic [QW-1:0] slot(logic [QW-1:0] head, logic [QW:0] off);
        logic [QW+1:0] s;
        s = {2'b00, head} + {1'b0, off};
        if (s >= (QW+2)'(QUEUE_DEPTH)) begin
            s = s - (QW+2)'(QUEUE_DEPTH);
        end
        return s[QW-1:0];
    endfunction

    function automatic logic chan_ok(logic [4:0] ch);
        return (ch >= 5'd1) && (ch <= 5'(CHANNELS));
    endfunction

    function automatic logic [NA-1:0] naddr(logic [4:0] ch, logic [6:0] note);
        logic [4:0] m;
        m = ch - 5'd1;
        return {m[CW-1:0], note};
    endfunction

    assign in_acc  = i_valid && (r_state == S_IDLE);
    assign o_stall = (r_state != S_IDLE);
    assign q_rd    = t_entry'(q_rdata);
    assign nm_rd   = t_note_word'(nm_rdata);

    always_comb begin
        new_ent.due   = r_t;
        new_ent.kind  = r_kind;
        new_ent.ch    = r_ch;
        new_ent.note  = r_note;
        new_ent.value = r_val;
        new_ent.ctl   = r_ctl;
        new_ent.inst  = r_id;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_head    = r_head;
        n_pos     = r_pos;
        n_seen    = r_seen;
        n_running = i_cfg_we ? i_cfg_wdata : r_running;
        n_clr     = r_clr;
        n_sweep   = r_sweep;
        n_pidx    = r_pidx;
        n_ent     = r_ent;
        q_we      = 1'b0;
        q_waddr   = slot(r_head, r_pos);
        q_wdata   = new_ent;
        q_raddr   = r_head;
        nm_we     = 1'b0;
        nm_waddr  = naddr(r_ent.ch, r_ent.note);
        nm_wdata  = '0;
        nm_raddr  = naddr(r_ent.ch, r_ent.note);
        ob_ctl    = '0;

        case (r_state)
            S_INIT: begin
                nm_we    = 1'b1;
                nm_waddr = r_clr;
                if (r_clr == CLR_LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    case (i_opcode)
                        OP_SCHED: begin
                            if (r_count >= QFULL) begin
                                n_state = S_OVF;
                            end else begin
                                n_pos   = r_count;
                                n_state = S_INS_RD;
                            end
                        end
                        OP_TICK: begin
                            n_state = r_running ? S_TK_RD : S_IDLE;
                        end
                        OP_PANIC: begin
                            n_count = '0;
                            if (i_panic_block == BLK_FIRST) begin
                                n_seen = 1'b0;
                            end
                            if (chan_ok(i_channel)) begin
                                n_pidx  = '0;
                                n_state = S_PN_RD;
                            end else begin
                                n_state = S_PN_END;
                            end
                        end
                        default: begin
                            n_count = '0;
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                if (r_pos == '0) begin
                    q_we    = 1'b1;
                    n_count = r_count + 1'b1;
                    n_state = S_IDLE;
                end else begin
                    q_raddr = slot(r_head, r_pos - 1'b1);
                    n_state = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                q_we = 1'b1;
                if (q_rd.due > r_t) begin
                    // shift the later entry up one place
                    q_wdata = q_rd;
                    n_pos   = r_pos - 1'b1;
                    n_state = S_INS_RD;
                end else begin
                    n_count = r_count + 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_TK_RD: begin
                n_state = (r_count == '0) ? S_FIN : S_TK_CMP;
            end
            S_TK_CMP: begin
                if (q_rd.due <= r_t) begin
                    n_ent   = q_rd;
                    n_head  = slot(r_head, (QW+1)'(1));
                    n_count = r_count - 1'b1;
                    n_state = S_TK_NRD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_TK_NRD: begin
                n_state = S_TK_EXEC;
            end
            S_TK_EXEC: begin
                if (ob_ready) begin
                    n_state = S_TK_RD;
                    case (r_ent.kind)
                        EV_ON: begin
                            if (chan_ok(r_ent.ch)) begin
                                nm_we         = 1'b1;
                                nm_wdata.active = 1'b1;
                                nm_wdata.inst = r_ent.inst;
                            end
                            ob_ctl.push = 1'b1;
                            ob_ctl.res  = mk_res(KIND_ON, r_ent.ch, r_ent.note, r_ent.value,
                                                 7'd0);
                        end
                        EV_OFF: begin
                            if (chan_ok(r_ent.ch) && nm_rd.active && nm_rd.inst == r_ent.inst)
                            begin
                                nm_we       = 1'b1;
                                ob_ctl.push = 1'b1;
                                ob_ctl.res  = mk_res(KIND_OFF, r_ent.ch, r_ent.note, 7'd0,
                                                     7'd0);
                            end
                        end
                        EV_ALL: begin
                            ob_ctl.push = 1'b1;
                            ob_ctl.res  = mk_res(KIND_ALL, r_ent.ch, 7'd0, 7'd0, 7'd0);
                            if (chan_ok(r_ent.ch)) begin
                                n_sweep = '0;
                                n_state = S_ALL_SWEEP;
                            end
                        end
                        default: begin
                            ob_ctl.push = 1'b1;
                            ob_ctl.res  = mk_res(KIND_CC, r_ent.ch, 7'd0, r_ent.value,
                                                 r_ent.ctl);
                        end
                    endcase
                end
            end
            S_ALL_SWEEP: begin
                nm_we    = 1'b1;
                nm_waddr = naddr(r_ent.ch, r_sweep);
                if (r_sweep == 7'(NOTES - 1)) begin
                    n_state = S_TK_RD;
                end else begin
                    n_sweep = r_sweep + 1'b1;
                end
            end
            S_PN_RD: begin
                nm_raddr = naddr(r_ch, {r_blk, r_pidx});
                n_state  = S_PN_CHK;
            end
            S_PN_CHK: begin
                nm_raddr = naddr(r_ch, {r_blk, r_pidx});
                nm_waddr = naddr(r_ch, {r_blk, r_pidx});
                if (!nm_rd.active || ob_ready) begin
                    if (nm_rd.active) begin
                        nm_we       = 1'b1;
                        n_seen      = 1'b1;
                        ob_ctl.push = 1'b1;
                        ob_ctl.res  = mk_res(KIND_OFF, r_ch, {r_blk, r_pidx}, 7'd0, 7'd0);
                    end
                    if (r_pidx == {BLK_IDX_W{1'b1}}) begin
                        n_state = S_PN_END;
                    end else begin
                        n_pidx  = r_pidx + 1'b1;
                        n_state = S_PN_RD;
                    end
                end
            end
            S_PN_END: begin
                if (r_blk != BLK_LAST) begin
                    n_state = S_FIN;
                end else if (!r_seen) begin
                    n_state = S_FIN;
                end else if (ob_ready) begin
                    ob_ctl.push = 1'b1;
                    ob_ctl.res  = mk_res(KIND_ALL, r_ch, 7'd0, 7'd0, 7'd0);
                    n_seen      = 1'b0;
                    n_state     = S_FIN;
                end
            end
            S_OVF: begin
                if (ob_ready) begin
                    ob_ctl.push = 1'b1;
                    ob_ctl.res  = mk_res(KIND_OVF, 5'd0, 7'd0, 7'd0, 7'd0);
                    n_state     = S_FIN;
                end
            end
            S_FIN: begin
                // release the held result as the last one
                ob_ctl.flush = 1'b1;
                if (ob_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_count   <= '0;
            r_head    <= '0;
            r_seen    <= 1'b0;
            r_running <= 1'b0;
            r_clr     <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_head    <= n_head;
            r_seen    <= n_seen;
            r_running <= n_running;
            r_clr     <= n_clr;
            r_pos     <= n_pos;
            r_sweep   <= n_sweep;
            r_pidx    <= n_pidx;
            r_ent     <= n_ent;
            if (in_acc) begin
                r_t    <= i_time_ms;
                r_kind <= i_event_kind;
                r_ch   <= i_channel;
                r_note <= i_note;
                r_val  <= i_value;
                r_ctl  <= i_controller;
                r_id   <= i_instance_id;
                r_blk  <= i_panic_block;
            end
        end
    end

    tmed_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (QUEUE_DEPTH),
        .AW    (QW)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    tmed_ram #(
        .WIDTH ($bits(t_note_word)),
        .DEPTH (ND),
        .AW    (NA)
    ) u_note_ram (
        .i_clk   (i_clk),
        .i_we    (nm_we),
        .i_waddr (nm_waddr),
        .i_wdata (nm_wdata),
        .i_raddr (nm_raddr),
        .o_rdata (nm_rdata)
    );

    tmed_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ob_ctl),
        .o_ready (ob_ready),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_res   (ob_res),
        .o_last  (o_last)
    );

    assign o_out_kind       = ob_res.kind;
    assign o_out_channel    = ob_res.ch;
    assign o_out_note       = ob_res.note;
    assign o_out_value      = ob_res.value;
    assign o_out_controller = ob_res.ctl;

    `TMED_ASSERT_IMPL(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= QFULL)
    `TMED_ASSERT_IMPL(a_push_ready, i_clk, i_rst_n, ob_ctl.push, ob_ready)
    `TMED_ASSERT_IMPL(a_qwe_insert, i_clk, i_rst_n, q_we, r_state == S_INS_RD || r_state == S_INS_CMP)
    `TMED_ASSERT_NEXT(a_init_quiet, i_clk, i_rst_n, r_state == S_INIT, !o_valid)

endmodule
